### src/iral_pkg.sv
`default_nettype none
package iral_pkg;

    localparam int TIME_W     = 32;
    localparam int IDX_OUT_W  = 5;
    localparam int ROOM_OUT_W = 6;

    typedef struct packed {
        logic load;
        logic scan;
        logic room;
        logic place;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic scan_end;
        logic room_end;
        logic place_last;
        logic emit_end;
    } status_t;

endpackage
`default_nettype wire

### src/iral_ram.sv
`default_nettype none
module iral_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### src/iral_ctrl.sv
`default_nettype none
module iral_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             final_stay,
    input  wire iral_pkg::status_t status,
    output iral_pkg::cmd_t         cmd,
    output logic                  busy
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_ROOM  = 5'b00100,
        ST_PLACE = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && final_stay)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = ST_ROOM;
                end
            end
            ST_ROOM:
            begin
                if (status.room_end)
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                state_next = status.place_last ? ST_EMIT : ST_SCAN;
            end
            ST_EMIT:
            begin
                if (status.emit_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign cmd.load  = start && (state_reg == ST_IDLE);
    assign cmd.scan  = (state_reg == ST_SCAN);
    assign cmd.room  = (state_reg == ST_ROOM);
    assign cmd.place = (state_reg == ST_PLACE);
    assign cmd.emit  = (state_reg == ST_EMIT);

endmodule
`default_nettype wire

### src/iral_dp.sv
`default_nettype none
module iral_dp #(
    parameter int MAX_STAYS = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire iral_pkg::cmd_t                      cmd,
    input  wire logic [iral_pkg::TIME_W-1:0]         arrival_time,
    input  wire logic [iral_pkg::TIME_W-1:0]         departure_time,
    output iral_pkg::status_t                        status,
    output logic                                     result_valid,
    output logic      [iral_pkg::IDX_OUT_W-1:0]      stay_index,
    output logic      [iral_pkg::ROOM_OUT_W-1:0]     room_number,
    output logic      [iral_pkg::ROOM_OUT_W-1:0]     rooms_used,
    output logic                                     overflowed,
    output logic                                     end_of_set
);

    localparam int TW   = iral_pkg::TIME_W;
    localparam int IW   = $clog2(MAX_STAYS);
    localparam int CW   = $clog2(MAX_STAYS + 1);
    localparam int KW   = 2 * TW + IW;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rc_reg, rc_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] walk_reg, walk_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          have_last_reg, have_last_next;
    logic [KW-1:0] last_key_reg, last_key_next;
    logic          found_reg, found_next;
    logic [KW-1:0] best_key_reg, best_key_next;
    logic          rfound_reg, rfound_next;
    logic [TW-1:0] rbest_end_reg, rbest_end_next;
    logic [IW-1:0] rbest_reg, rbest_next;

    logic            full;
    logic [IW-1:0]   walk_idx;
    logic [IW-1:0]   prev_idx;
    logic [2*TW-1:0] stay_rdata;
    logic [TW-1:0]   room_rdata;
    logic [CW-1:0]   asg_rdata;
    logic [KW-1:0]   cand_key;
    logic            cand_take;
    logic            room_take;
    logic [TW-1:0]   best_arr;
    logic [TW-1:0]   best_dep;
    logic [IW-1:0]   best_idx;
    logic [IW-1:0]   target;

    assign full     = (count_reg == CW'(MAX_STAYS));
    assign walk_idx = walk_reg[IW-1:0];
    assign prev_idx = IW'(walk_reg - CW'(1));

    // key order: departure, then arrival, then input position
    assign best_dep = best_key_reg[KW-1 -: TW];
    assign best_arr = best_key_reg[IW +: TW];
    assign best_idx = best_key_reg[IW-1:0];
    assign cand_key = {stay_rdata[TW-1:0], stay_rdata[2*TW-1:TW], prev_idx};
    assign cand_take = (walk_reg != '0)
                     && (!have_last_reg || (cand_key > last_key_reg))
                     && (!found_reg || (cand_key < best_key_reg));
    assign room_take = (walk_reg != '0) && (room_rdata < best_arr)
                     && (!rfound_reg || (room_rdata >= rbest_end_reg));
    assign target    = rfound_reg ? rbest_reg : rc_reg[IW-1:0];

    assign status.scan_end   = (walk_reg == count_reg);
    assign status.room_end   = (walk_reg == rc_reg);
    assign status.place_last = ((pos_reg + CW'(1)) == count_reg);
    assign status.emit_end   = (walk_reg == count_reg);

    iral_ram #(.WIDTH(2 * TW), .DEPTH(MAX_STAYS)) u_stay_ram (
        .clk   (clk),
        .we    (cmd.load && !full),
        .waddr (count_reg[IW-1:0]),
        .wdata ({arrival_time, departure_time}),
        .raddr (walk_idx),
        .rdata (stay_rdata)
    );

    iral_ram #(.WIDTH(TW), .DEPTH(MAX_STAYS)) u_room_ram (
        .clk   (clk),
        .we    (cmd.place),
        .waddr (target),
        .wdata (best_dep),
        .raddr (walk_idx),
        .rdata (room_rdata)
    );

    iral_ram #(.WIDTH(CW), .DEPTH(MAX_STAYS)) u_asg_ram (
        .clk   (clk),
        .we    (cmd.place),
        .waddr (best_idx),
        .wdata (CW'(target) + CW'(1)),
        .raddr (walk_idx),
        .rdata (asg_rdata)
    );

    always_comb
    begin
        count_next     = count_reg;
        rc_next        = rc_reg;
        ovf_next       = ovf_reg;
        walk_next      = walk_reg;
        pos_next       = pos_reg;
        have_last_next = have_last_reg;
        last_key_next  = last_key_reg;
        found_next     = found_reg;
        best_key_next  = best_key_reg;
        rfound_next    = rfound_reg;
        rbest_end_next = rbest_end_reg;
        rbest_next     = rbest_reg;

        if (cmd.load)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
            walk_next      = '0;
            pos_next       = '0;
            have_last_next = 1'b0;
            found_next     = 1'b0;
        end

        if (cmd.scan)
        begin
            if (cand_take)
            begin
                found_next    = 1'b1;
                best_key_next = cand_key;
            end
            if (status.scan_end)
            begin
                walk_next   = '0;
                rfound_next = 1'b0;
            end
            else
            begin
                walk_next = walk_reg + CW'(1);
            end
        end

        if (cmd.room)
        begin
            if (room_take)
            begin
                rfound_next    = 1'b1;
                rbest_end_next = room_rdata;
                rbest_next     = prev_idx;
            end
            walk_next = status.room_end ? '0 : walk_reg + CW'(1);
        end

        if (cmd.place)
        begin
            if (!rfound_reg)
            begin
                rc_next = rc_reg + CW'(1);
            end
            last_key_next  = best_key_reg;
            have_last_next = 1'b1;
            found_next     = 1'b0;
            pos_next       = pos_reg + CW'(1);
            walk_next      = '0;
        end

        if (cmd.emit)
        begin
            if (status.emit_end)
            begin
                walk_next  = '0;
                count_next = '0;
                rc_next    = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                walk_next = walk_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rc_reg        <= '0;
            ovf_reg       <= 1'b0;
            walk_reg      <= '0;
            pos_reg       <= '0;
            have_last_reg <= 1'b0;
            found_reg     <= 1'b0;
            rfound_reg    <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rc_reg        <= rc_next;
            ovf_reg       <= ovf_next;
            walk_reg      <= walk_next;
            pos_reg       <= pos_next;
            have_last_reg <= have_last_next;
            found_reg     <= found_next;
            rfound_reg    <= rfound_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_key_reg  <= last_key_next;
        best_key_reg  <= best_key_next;
        rbest_end_reg <= rbest_end_next;
        rbest_reg     <= rbest_next;
    end

    // assignment read for entry walk-1 lands while walk points one ahead
    assign result_valid = cmd.emit && (walk_reg != '0);
    assign stay_index   = iral_pkg::IDX_OUT_W'(prev_idx);
    assign room_number  = iral_pkg::ROOM_OUT_W'(asg_rdata);
    assign rooms_used   = iral_pkg::ROOM_OUT_W'(rc_reg);
    assign overflowed   = ovf_reg;
    assign end_of_set   = result_valid && status.emit_end;

endmodule
`default_nettype wire

### src/interval_room_allocator.sv
`default_nettype none
// Interval room allocator. Stays load one per cycle while busy is low (start
// high); the stay with final_stay set closes the set. Then, for each of the n
// stored stays, a scan of the stay memory picks the next stay in
// departure/arrival/position order, a scan of the room memory picks its room,
// and a separate state records it; the scans walk one entry at a time because
// each memory has a single read port. Results follow in input order, one per
// cycle on result_valid; they cannot be stalled.
// Stays beyond MAX_STAYS are dropped and reported through overflowed.
module interval_room_allocator #(
    parameter int MAX_STAYS = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [iral_pkg::TIME_W-1:0]         arrival_time,
    input  wire logic [iral_pkg::TIME_W-1:0]         departure_time,
    input  wire logic                                final_stay,
    output logic                                     result_valid,
    output logic      [iral_pkg::IDX_OUT_W-1:0]      stay_index,
    output logic      [iral_pkg::ROOM_OUT_W-1:0]     room_number,
    output logic      [iral_pkg::ROOM_OUT_W-1:0]     rooms_used,
    output logic                                     overflowed,
    output logic                                     end_of_set
);

    iral_pkg::cmd_t    cmd;
    iral_pkg::status_t status;

    iral_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .final_stay (final_stay),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy)
    );

    iral_dp #(.MAX_STAYS(MAX_STAYS)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .arrival_time   (arrival_time),
        .departure_time (departure_time),
        .status         (status),
        .result_valid   (result_valid),
        .stay_index     (stay_index),
        .room_number    (room_number),
        .rooms_used     (rooms_used),
        .overflowed     (overflowed),
        .end_of_set     (end_of_set)
    );

    a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result outside a run");

    a_room_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && MAX_STAYS < 64) |-> (room_number != '0 && room_number <= rooms_used))
        else $error("room number out of range");

    a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        end_of_set |=> !busy)
        else $error("block still busy after last result");

endmodule
`default_nettype wire

### verif/interval_room_allocator_test.sv
`default_nettype none
module interval_room_allocator_test;

    localparam int CAPACITY  = 32;
    localparam int CYCLE_CAP = 600000;

    typedef struct packed {
        logic [iral_pkg::IDX_OUT_W-1:0]  idx;
        logic [iral_pkg::ROOM_OUT_W-1:0] room;
        logic [iral_pkg::ROOM_OUT_W-1:0] rooms;
        logic                            ovf;
        logic                            eos;
    } room_slip_t;

    typedef struct {
        logic [iral_pkg::TIME_W-1:0] arr;
        logic [iral_pkg::TIME_W-1:0] dep;
        logic                        fin;
        bit                          typed;
    } stay_row_t;

    logic                            clk = 0;
    logic                            rst_n = 0;
    logic                            start = 0;
    logic                            busy;
    logic [iral_pkg::TIME_W-1:0]     arrival_time = '0;
    logic [iral_pkg::TIME_W-1:0]     departure_time = '0;
    logic                            final_stay = 0;
    logic                            result_valid;
    logic [iral_pkg::IDX_OUT_W-1:0]  stay_index;
    logic [iral_pkg::ROOM_OUT_W-1:0] room_number;
    logic [iral_pkg::ROOM_OUT_W-1:0] rooms_used;
    logic                            overflowed;
    logic                            end_of_set;

    interval_room_allocator #(.MAX_STAYS(CAPACITY)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .arrival_time(arrival_time), .departure_time(departure_time),
        .final_stay(final_stay), .result_valid(result_valid),
        .stay_index(stay_index), .room_number(room_number),
        .rooms_used(rooms_used), .overflowed(overflowed), .end_of_set(end_of_set)
    );

    always #10 clk = ~clk;

    // predictor state
    logic [iral_pkg::TIME_W-1:0] held_arr [CAPACITY];
    logic [iral_pkg::TIME_W-1:0] held_dep [CAPACITY];
    int                          held_cnt = 0;
    bit                          held_ovf = 0;
    room_slip_t                  slips_due [$];

    int  errors = 0;
    int  sets_done = 0;
    int  ovf_sets = 0;
    int  slips_seen = 0;
    int  cycles = 0;

    function automatic bit runs_first(int x, int y);
        if (held_dep[x] != held_dep[y]) return held_dep[x] < held_dep[y];
        if (held_arr[x] != held_arr[y]) return held_arr[x] < held_arr[y];
        return x < y;
    endfunction

    function automatic void queue_slip(room_slip_t sl);
        slips_due = {slips_due, sl};
    endfunction

    // sort by departure/arrival/position, then greedy room placement
    function automatic void book_rooms();
        int                          order [CAPACITY];
        logic [iral_pkg::TIME_W-1:0] room_end [CAPACITY];
        logic [5:0]                  given [CAPACITY];
        int                          opened, k, s, best;
        bit                          found;
        room_slip_t                  sl;
        opened = 0;
        for (int i = 0; i < held_cnt; i++) begin
            k = i;
            while (k > 0 && runs_first(i, order[k-1])) begin
                order[k] = order[k-1];
                k--;
            end
            order[k] = i;
        end
        for (int p = 0; p < held_cnt; p++) begin
            s = order[p];
            found = 0;
            best = 0;
            for (int r = 0; r < opened; r++)
                if (room_end[r] < held_arr[s] && (!found || room_end[r] >= room_end[best]))
                begin
                    best = r;
                    found = 1;
                end
            if (!found) begin
                best = opened;
                opened++;
            end
            room_end[best] = held_dep[s];
            given[s] = 6'(best + 1);
        end
        for (int i = 0; i < held_cnt; i++) begin
            sl.idx   = 5'(i);
            sl.room  = given[i];
            sl.rooms = 6'(opened);
            sl.ovf   = held_ovf;
            sl.eos   = (i + 1 == held_cnt);
            queue_slip(sl);
        end
    endfunction

    function automatic void take_stay(stay_row_t row);
        room_slip_t sl;
        if (held_cnt < CAPACITY) begin
            held_arr[held_cnt] = row.arr;
            held_dep[held_cnt] = row.dep;
            held_cnt++;
        end else
            held_ovf = 1;
        if (!row.fin) return;
        if (row.typed) begin
            // lone stay: always room 1 of 1
            sl = '{idx: '0, room: 6'd1, rooms: 6'd1, ovf: 1'b0, eos: 1'b1};
            queue_slip(sl);
        end else
            book_rooms();
        sets_done++;
        if (held_ovf) ovf_sets++;
        held_cnt = 0;
        held_ovf = 0;
    endfunction

    // one transfer; start stays high across back-to-back items
    task automatic send_stay(stay_row_t row, int gap);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        arrival_time <= row.arr;
        departure_time <= row.dep;
        final_stay <= row.fin;
        @(posedge clk);
        while (busy) @(posedge clk);
        take_stay(row);
    endtask

    always @(posedge clk) begin
        room_slip_t want;
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("interval_room_allocator: mismatch");
            $finish;
        end else if (rst_n && result_valid) begin
            slips_seen++;
            if (slips_due.size() == 0) begin
                $error("result with nothing expected: stay_index %0d", stay_index);
                errors++;
            end else begin
                want = slips_due.pop_front();
                if (stay_index !== want.idx) begin
                    $error("stay_index exp %0d got %0d", want.idx, stay_index);
                    errors++;
                end
                if (room_number !== want.room) begin
                    $error("room_number exp %0d got %0d", want.room, room_number);
                    errors++;
                end
                if (rooms_used !== want.rooms) begin
                    $error("rooms_used exp %0d got %0d", want.rooms, rooms_used);
                    errors++;
                end
                if (overflowed !== want.ovf) begin
                    $error("overflowed exp %0d got %0d", want.ovf, overflowed);
                    errors++;
                end
                if (end_of_set !== want.eos) begin
                    $error("end_of_set exp %0d got %0d", want.eos, end_of_set);
                    errors++;
                end
            end
        end
    end

    function automatic logic [iral_pkg::TIME_W-1:0] pick_time(bit wide,
                                                             logic [iral_pkg::TIME_W-1:0] base);
        if (wide) return $urandom;
        return base + $urandom_range(0, 12);
    endfunction

    stay_row_t directed [] = '{
        '{32'd0, 32'd0, 1'b1, 1'b1},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1},
        '{32'd5, 32'd2, 1'b1, 1'b1},                // departure before arrival
        '{32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1},
        '{32'd1, 32'd5, 1'b0, 1'b0},                // touching: 5 is not below 5
        '{32'd5, 32'd9, 1'b0, 1'b0},
        '{32'd6, 32'd9, 1'b0, 1'b0},
        '{32'd6, 32'd9, 1'b0, 1'b0},
        '{32'd10, 32'd12, 1'b0, 1'b0},
        '{32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0},
        '{32'd3, 32'd4, 1'b0, 1'b0},                // full ties, broken by position
        '{32'd3, 32'd4, 1'b0, 1'b0},
        '{32'd3, 32'd4, 1'b0, 1'b0},
        '{32'd8, 32'd9, 1'b0, 1'b0},
        '{32'd8, 32'd9, 1'b1, 1'b0},
        '{32'd10, 32'd20, 1'b0, 1'b0},
        '{32'd0, 32'd5, 1'b0, 1'b0},
        '{32'd6, 32'd8, 1'b0, 1'b0},
        '{32'd21, 32'd30, 1'b0, 1'b0},
        '{32'd9, 32'd9, 1'b1, 1'b0}
    };

    initial begin
        stay_row_t                   row;
        int                          sent, set_len, gap;
        bit                          wide;
        logic [iral_pkg::TIME_W-1:0] a;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (directed[i]) send_stay(directed[i], 0);
        sent = 0;
        while (sent < 340) begin
            // mostly short sets, now and then a long one that may pass capacity
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
                                                  : $urandom_range(1, 8);
            wide = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < set_len; j++) begin
                a = pick_time(wide, 32'd0) + (wide ? 0 : $urandom_range(0, 30));
                row.arr = a;
                row.dep = ($urandom_range(0, 15) == 0) ? pick_time(1, 0)
                                                       : pick_time(wide, a);
                row.fin = (j == set_len - 1);
                row.typed = 0;
                gap = (sent < 270 && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
                send_stay(row, gap);
                sent++;
            end
        end
        start <= 0;
        while (slips_due.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d sets (%0d with dropped stays), %0d results checked",
                 sets_done, ovf_sets, slips_seen);
        if (errors == 0)
            $display("interval_room_allocator: match");
        else
            $display("interval_room_allocator: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

### interval_room_allocator.f
src/iral_pkg.sv
src/iral_ram.sv
src/iral_ctrl.sv
src/iral_dp.sv
src/interval_room_allocator.sv
verif/interval_room_allocator_test.sv
